/* design/mipd_pkg.sv */
package mipd_pkg;

    localparam int unsigned CHAN_IDX_W = 5;

    localparam logic [5:0] PHASE_DATA_END = 6'd32;
    localparam logic [5:0] PHASE_LEADER   = 6'd62;
    localparam logic [5:0] PHASE_IDLE     = 6'd63;

    localparam logic [15:0] LEADER_MARK_RST  = 16'd9000;
    localparam logic [15:0] LEADER_SPACE_RST = 16'd4500;
    localparam logic [15:0] SHORT_PULSE_RST  = 16'd562;
    localparam logic [15:0] LONG_PULSE_RST   = 16'd1687;

    localparam logic [31:0] FIRST_BIT = 32'h8000_0000;

    // x/10 = (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2^19
    localparam logic [18:0] DIV10_MUL   = 19'd419431;
    localparam int unsigned DIV10_SHIFT = 22;
    // x/7 = (x * DIV7_MUL) >> DIV7_SHIFT, exact for x below 2^20
    localparam logic [20:0] DIV7_MUL    = 21'd1198373;
    localparam int unsigned DIV7_SHIFT  = 23;

    typedef enum logic [7:0] {
        REG_LEADER_MARK  = 8'd0,
        REG_LEADER_SPACE = 8'd1,
        REG_SHORT_PULSE  = 8'd2,
        REG_LONG_PULSE   = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic [31:0] edge_time;
        logic [31:0] shift_word;
        logic [5:0]  bit_phase;
    } chan_rec_t;

    localparam chan_rec_t CHAN_REC_RST = '{
        edge_time:  32'd0,
        shift_word: 32'd0,
        bit_phase:  PHASE_IDLE
    };

    typedef struct packed {
        logic                  load;
        logic                  issue;
        logic [CHAN_IDX_W-1:0] chan;
        logic                  finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic logic [15:0] win_lo(input logic [15:0] nominal);
        logic [18:0] x;
        logic [37:0] p;
        x = 19'(nominal) * 19'd7;
        p = 38'(x) * 38'(DIV10_MUL);
        return p[DIV10_SHIFT +: 16];
    endfunction

    function automatic logic [16:0] win_hi(input logic [15:0] nominal);
        logic [19:0] x;
        logic [40:0] p;
        x = 20'(nominal) * 20'd10;
        p = 41'(x) * 41'(DIV7_MUL);
        return p[DIV7_SHIFT +: 17];
    endfunction

endpackage

/* design/multichannel_ir_pulse_decoder.sv */
// Multichannel NEC-style infrared decoder. Each input beat carries a 32-bit
// timestamp and the levels of all receiver pins; every beat gives exactly one
// output beat holding the 32-bit code completed in that sample by the
// highest-index channel, or zero if no channel completed one. Channels are
// visited one per cycle through a single record memory with a two-stage
// read/length/decode pipeline; the next sample is accepted only after the
// scan of all channels has ended and its result has entered the output
// register, which holds it, and the next sample is taken while it waits.
// Pulse windows are nominal*7/10 to nominal*10/7 ticks; a written length
// register takes effect once the window thresholds are registered from it.
module multichannel_ir_pulse_decoder #(
    parameter int unsigned CHANNELS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // sample_time[31:0], pin_levels[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // received_code[31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mipd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mipd_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mipd_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_time (s_tdata[31:0]),
        .pin_levels  (s_tdata[63:32]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* design/mipd_ram.sv */
module mipd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/mipd_ctrl.sv */
module mipd_ctrl #(
    parameter int unsigned CHANNELS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mipd_pkg::dp_status_t  status,
    output mipd_pkg::ctrl_cmd_t   cmd
);
    import mipd_pkg::*;

    localparam int unsigned CNT_W = $clog2(CHANNELS + 3);
    localparam logic [CNT_W-1:0] CNT_CHANNELS = CNT_W'(CHANNELS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHANNELS + 2);

    ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = status.out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.issue  = 1'b0;
        cmd.chan   = CHAN_IDX_W'(cnt_reg);
        cmd.finish = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN: begin
                cmd.issue  = (cnt_reg < CNT_CHANNELS);
                cmd.finish = (cnt_reg == CNT_LAST) && status.out_free;
            end
            ST_HOLD: begin
                cmd.finish = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* design/mipd_datapath.sv */
module mipd_datapath #(
    parameter int unsigned CHANNELS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [31:0]           sample_time,
    input  logic [31:0]           pin_levels,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  mipd_pkg::ctrl_cmd_t   cmd,
    output mipd_pkg::dp_status_t  status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata
);
    import mipd_pkg::*;

    localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned REC_W = $bits(chan_rec_t);

    logic [15:0] leader_mark_reg, leader_space_reg, short_pulse_reg, long_pulse_reg;
    logic [15:0] mark_lo_reg, space_lo_reg, short_lo_reg, long_lo_reg;
    logic [16:0] mark_hi_reg, space_hi_reg, short_hi_reg, long_hi_reg;

    logic [31:0] now_reg;
    logic [31:0] pins_reg;
    logic [31:0] result_reg;
    logic [CHANNELS-1:0] line_level_reg;
    logic [CHANNELS-1:0] entry_valid_reg;

    logic          s1_valid_reg;
    logic [AW-1:0] s1_chan_reg;
    logic          s1_rvalid_reg;

    logic          s2_valid_reg;
    logic [AW-1:0] s2_chan_reg;
    logic          s2_changed_reg;
    logic          s2_high_reg;
    logic [31:0]   s2_len_reg;
    logic [31:0]   s2_word_reg;
    logic [5:0]    s2_phase_reg;

    logic          m_tvalid_reg;
    logic [31:0]   m_tdata_reg;

    logic [REC_W-1:0] ram_rdata;
    chan_rec_t        s1_rec;
    chan_rec_t        wr_rec;
    logic             wr_en;
    logic             s1_high;
    logic             s1_changed;

    logic        hit_mark, hit_space, hit_short, hit_long;
    logic [31:0] new_word;
    logic [5:0]  new_phase;
    logic        code_done;

    // configuration and window thresholds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leader_mark_reg  <= LEADER_MARK_RST;
            leader_space_reg <= LEADER_SPACE_RST;
            short_pulse_reg  <= SHORT_PULSE_RST;
            long_pulse_reg   <= LONG_PULSE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LEADER_MARK:  leader_mark_reg  <= cfg_data;
                REG_LEADER_SPACE: leader_space_reg <= cfg_data;
                REG_SHORT_PULSE:  short_pulse_reg  <= cfg_data;
                REG_LONG_PULSE:   long_pulse_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        mark_lo_reg  <= win_lo(leader_mark_reg);
        mark_hi_reg  <= win_hi(leader_mark_reg);
        space_lo_reg <= win_lo(leader_space_reg);
        space_hi_reg <= win_hi(leader_space_reg);
        short_lo_reg <= win_lo(short_pulse_reg);
        short_hi_reg <= win_hi(short_pulse_reg);
        long_lo_reg  <= win_lo(long_pulse_reg);
        long_hi_reg  <= win_hi(long_pulse_reg);
    end

    // per-channel record store
    mipd_ram #(
        .WIDTH (REC_W),
        .DEPTH (CHANNELS)
    ) u_rec_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (s2_chan_reg),
        .wdata (wr_rec),
        .raddr (cmd.chan[AW-1:0]),
        .rdata (ram_rdata)
    );

    // stage 1: record read back, pulse length
    always_comb begin
        s1_rec     = s1_rvalid_reg ? chan_rec_t'(ram_rdata) : CHAN_REC_RST;
        s1_high    = line_level_reg[s1_chan_reg];
        s1_changed = pins_reg[s1_chan_reg] != s1_high;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_chan_reg    <= cmd.chan[AW-1:0];
        s1_rvalid_reg  <= entry_valid_reg[cmd.chan[AW-1:0]];
        s2_chan_reg    <= s1_chan_reg;
        s2_changed_reg <= s1_changed;
        s2_high_reg    <= s1_high;
        s2_len_reg     <= now_reg - s1_rec.edge_time;
        s2_word_reg    <= s1_rec.shift_word;
        s2_phase_reg   <= s1_rec.bit_phase;
    end

    // stage 2: window checks and decoder step
    always_comb begin
        hit_mark  = (s2_len_reg >= 32'(mark_lo_reg))  && (s2_len_reg <= 32'(mark_hi_reg));
        hit_space = (s2_len_reg >= 32'(space_lo_reg)) && (s2_len_reg <= 32'(space_hi_reg));
        hit_short = (s2_len_reg >= 32'(short_lo_reg)) && (s2_len_reg <= 32'(short_hi_reg));
        hit_long  = (s2_len_reg >= 32'(long_lo_reg))  && (s2_len_reg <= 32'(long_hi_reg));
    end

    always_comb begin
        new_word  = s2_word_reg;
        new_phase = s2_phase_reg;
        code_done = 1'b0;
        if (!s2_high_reg && hit_mark) begin
            new_phase = PHASE_LEADER;
            new_word  = '0;
        end else if (s2_high_reg && s2_phase_reg == PHASE_LEADER && hit_space) begin
            new_phase = '0;
        end else if (s2_phase_reg == PHASE_LEADER || s2_phase_reg == PHASE_IDLE) begin
            new_phase = s2_phase_reg;
        end else if (!s2_high_reg && hit_short) begin
            // end mark after a full word
            if (s2_phase_reg[5]) begin
                new_phase = PHASE_IDLE;
                code_done = 1'b1;
            end
        end else if (s2_high_reg && hit_short) begin
            if (!s2_phase_reg[5]) begin
                new_word  = s2_word_reg | (FIRST_BIT >> s2_phase_reg[4:0]);
                new_phase = s2_phase_reg + 6'd1;
            end else begin
                new_phase = PHASE_DATA_END;
            end
        end else if (s2_high_reg && hit_long) begin
            new_phase = s2_phase_reg[5] ? PHASE_DATA_END : s2_phase_reg + 6'd1;
        end else begin
            new_phase = PHASE_IDLE;
        end
    end

    always_comb begin
        wr_en             = s2_valid_reg && s2_changed_reg;
        wr_rec.edge_time  = now_reg;
        wr_rec.shift_word = new_word;
        wr_rec.bit_phase  = new_phase;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_level_reg  <= '0;
            entry_valid_reg <= '0;
        end else if (wr_en) begin
            line_level_reg[s2_chan_reg]  <= !s2_high_reg;
            entry_valid_reg[s2_chan_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg    <= sample_time;
            pins_reg   <= pin_levels;
            result_reg <= '0;
        end else if (wr_en && code_done && s2_word_reg != '0) begin
            result_reg <= s2_word_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= result_reg;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

/* design/mipd_checker.sv */
module mipd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // one sample in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is being scanned");

    // a scan never finishes in the cycle after acceptance
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after input beat");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind multichannel_ir_pulse_decoder mipd_checker u_mipd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

/* bench/ir_code_checker.sv */
`timescale 1ns / 100ps

module ir_code_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,    // sample_time[31:0], pin_levels[63:32]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // received_code[31:0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int unsigned mismatch_count,
    output int unsigned codes_pending
);

    import mipd_pkg::*;

    logic [15:0] mark_nom;
    logic [15:0] space_nom;
    logic [15:0] short_nom;
    logic [15:0] long_nom;

    logic [31:0] last_edge [32];
    logic [31:0] levels;
    logic [31:0] code_acc [32];
    logic [5:0]  phase [32];

    logic [31:0] code_q [$];
    logic [31:0] expected;

    function automatic bit fits(input logic [31:0] len, input logic [15:0] nom);
        int unsigned lo;
        int unsigned hi;
        lo = (32'(nom) * 7) / 10;
        hi = (32'(nom) * 10) / 7;
        return (len >= lo) && (len <= hi);
    endfunction

    function automatic logic [31:0] decode_sample(input logic [31:0] stamp,
                                                  input logic [31:0] pins);
        logic [31:0] found;
        logic [31:0] len;
        logic [5:0]  ph;
        logic        was_high;
        found = '0;
        for (int i = 0; i < 32; i++) begin
            if (pins[i] != levels[i]) begin
                was_high = levels[i];
                ph       = phase[i];
                len      = stamp - last_edge[i];
                if (!was_high && fits(len, mark_nom)) begin
                    phase[i]    = PHASE_LEADER;
                    code_acc[i] = '0;
                end else if (was_high && ph == PHASE_LEADER && fits(len, space_nom)) begin
                    phase[i] = 6'd0;
                end else if (ph >= PHASE_LEADER) begin
                    // idle or leader incomplete: nothing else happens
                end else if (!was_high && fits(len, short_nom)) begin
                    if (ph >= PHASE_DATA_END) begin
                        phase[i] = PHASE_IDLE;
                        if (code_acc[i] != '0)
                            found = code_acc[i];
                    end
                end else if (was_high && fits(len, short_nom)) begin
                    if (ph < PHASE_DATA_END) begin
                        code_acc[i] = code_acc[i] | (FIRST_BIT >> ph);
                        phase[i]    = ph + 6'd1;
                    end else begin
                        phase[i] = PHASE_DATA_END;
                    end
                end else if (was_high && fits(len, long_nom)) begin
                    phase[i] = (ph < PHASE_DATA_END) ? ph + 6'd1 : PHASE_DATA_END;
                end else begin
                    phase[i] = PHASE_IDLE;
                end
                levels[i]    = pins[i];
                last_edge[i] = stamp;
            end
        end
        return found;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mark_nom  = LEADER_MARK_RST;
            space_nom = LEADER_SPACE_RST;
            short_nom = SHORT_PULSE_RST;
            long_nom  = LONG_PULSE_RST;
            levels    = '0;
            for (int i = 0; i < 32; i++) begin
                last_edge[i] = '0;
                code_acc[i]  = '0;
                phase[i]     = PHASE_IDLE;
            end
            code_q.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LEADER_MARK:  mark_nom  = cfg_data;
                    REG_LEADER_SPACE: space_nom = cfg_data;
                    REG_SHORT_PULSE:  short_nom = cfg_data;
                    REG_LONG_PULSE:   long_nom  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                code_q.push_back(decode_sample(s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready) begin
                if (code_q.size() == 0) begin
                    $error("received_code: unexpected beat, actual %h", m_tdata);
                    mismatch_count++;
                end else begin
                    expected = code_q.pop_front();
                    if (m_tdata !== expected) begin
                        $error("received_code: expected %h, actual %h", expected, m_tdata);
                        mismatch_count++;
                    end
                end
            end
        end
        codes_pending = code_q.size();
    end

endmodule

/* bench/multichannel_ir_pulse_decoder_tb.sv */
`timescale 1ns / 100ps

module multichannel_ir_pulse_decoder_tb;

    import mipd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned PHASE_ITEMS  = 105;
    localparam int unsigned SLOTS        = 4;
    localparam int unsigned MAX_EDGES    = 80;
    localparam int unsigned DRAIN_CYCLES = 60;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int unsigned mismatch_count;
    int unsigned codes_pending;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned send_calm   = 0;
    int unsigned recv_calm   = 0;

    logic [31:0] pins_now  = '0;
    logic [31:0] now_stamp = '0;

    logic [15:0] mark_set  = LEADER_MARK_RST;
    logic [15:0] space_set = LEADER_SPACE_RST;
    logic [15:0] short_set = SHORT_PULSE_RST;
    logic [15:0] long_set  = LONG_PULSE_RST;

    longint unsigned edge_at [SLOTS][MAX_EDGES];
    int unsigned     edge_cnt [SLOTS];
    int unsigned     edge_pos [SLOTS];
    int unsigned     slot_chan [SLOTS];

    multichannel_ir_pulse_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ir_code_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .codes_pending  (codes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 8);
    endfunction

    // pulse near the nominal length, now and then off the window
    function automatic int unsigned pulse_len(input logic [15:0] nom);
        int unsigned lo;
        int unsigned hi;
        int unsigned len;
        lo = (32'(nom) * 7) / 10;
        hi = (32'(nom) * 10) / 7;
        if ($urandom_range(0, 199) == 0) begin
            case ($urandom_range(0, 2))
                0:       len = (lo == 0) ? hi + 1 : lo - 1;
                1:       len = hi + 1;
                default: len = $urandom_range(1, 100000);
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0:       len = lo;
                1:       len = hi;
                2, 3:    len = nom;
                default: len = $urandom_range(hi, lo);
            endcase
        end
        return (len == 0) ? 1 : len;
    endfunction

    task automatic send_sample(input logic [31:0] stamp, input logic [31:0] pins);
        int unsigned gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {pins, stamp};
        do @(posedge aclk); while (!s_tready);
        pins_now  = pins;
        now_stamp = stamp;
        items_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (codes_pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_edge(input int unsigned slot, input longint unsigned at);
        edge_at[slot][edge_cnt[slot]] = at;
        edge_cnt[slot]++;
    endtask

    // leader, 32 data bits (maybe a few extra), end mark; sometimes cut short
    task automatic plan_frame(input int unsigned slot, input int unsigned ch,
                              input longint unsigned start, input logic [31:0] code);
        longint unsigned t;
        int unsigned     extra;
        bit              one;
        edge_cnt[slot] = 0;
        edge_pos[slot] = 0;
        t     = start;
        extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        if (!pins_now[ch]) begin
            add_edge(slot, t);
            t += $urandom_range(50, 30000);
        end
        add_edge(slot, t);
        t += pulse_len(mark_set);
        add_edge(slot, t);
        t += pulse_len(space_set);
        add_edge(slot, t);
        for (int b = 0; b < 32 + extra; b++) begin
            t += pulse_len(short_set);
            add_edge(slot, t);
            if (b < 32)
                one = code[31 - b];
            else
                one = $urandom_range(0, 1);
            t += pulse_len(one ? short_set : long_set);
            add_edge(slot, t);
        end
        t += pulse_len(short_set);
        add_edge(slot, t);
        if ($urandom_range(0, 9) == 0)
            edge_cnt[slot] = $urandom_range(1, edge_cnt[slot]);
    endtask

    // frames on a few channels at once, merged into one sample stream
    task automatic run_burst(input int unsigned stop_at);
        int unsigned     k;
        int unsigned     ch;
        int unsigned     pick;
        logic [31:0]     busy;
        logic [31:0]     pins;
        logic [31:0]     code;
        logic [31:0]     base;
        longint unsigned soonest;
        bit              any;
        k    = $urandom_range(1, SLOTS);
        busy = '0;
        if ($urandom_range(0, 9) == 0)
            now_stamp = 32'hFFFF_FFFF - $urandom_range(0, 150000);
        base = now_stamp + $urandom_range(1, 2000);
        for (int j = 0; j < SLOTS; j++) begin
            edge_cnt[j] = 0;
            edge_pos[j] = 0;
            if (j < k) begin
                do ch = $urandom_range(0, 31); while (busy[ch]);
                busy[ch]     = 1'b1;
                slot_chan[j] = ch;
                case ($urandom_range(0, 7))
                    0:       code = '0;
                    1:       code = '1;
                    default: code = $urandom;
                endcase
                plan_frame(j, ch, $urandom_range(0, 3000), code);
            end
        end
        any = 1'b1;
        while (any && items_sent < stop_at) begin
            any     = 1'b0;
            soonest = '1;
            for (int j = 0; j < SLOTS; j++) begin
                if (edge_pos[j] < edge_cnt[j] && edge_at[j][edge_pos[j]] < soonest) begin
                    soonest = edge_at[j][edge_pos[j]];
                    any     = 1'b1;
                end
            end
            if (any) begin
                pins = pins_now;
                for (int j = 0; j < SLOTS; j++) begin
                    if (edge_pos[j] < edge_cnt[j] && edge_at[j][edge_pos[j]] == soonest) begin
                        pins[slot_chan[j]] = ~pins[slot_chan[j]];
                        edge_pos[j]++;
                    end
                end
                if ($urandom_range(0, 15) == 0) begin
                    pick = $urandom_range(0, 31);
                    if (!busy[pick])
                        pins[pick] = ~pins[pick];
                end
                send_sample(base + soonest[31:0], pins);
            end
        end
    endtask

    task automatic run_noise();
        int unsigned n;
        int unsigned pick;
        logic [31:0] pins;
        n = $urandom_range(3, 10);
        repeat (n) begin
            pins = pins_now;
            pick = $urandom_range(0, 31);
            if ($urandom_range(0, 3) == 0)
                pins = $urandom;
            else
                pins[pick] = ~pins[pick];
            send_sample(now_stamp + $urandom_range(0, 20000), pins);
        end
    endtask

    task automatic run_phase(input logic [15:0] m, input logic [15:0] s,
                             input logic [15:0] sh, input logic [15:0] l,
                             input bit rewrite);
        int unsigned stop_at;
        if (rewrite) begin
            drain();
            write_reg(REG_LEADER_MARK, m);
            write_reg(REG_LEADER_SPACE, s);
            write_reg(REG_SHORT_PULSE, sh);
            write_reg(REG_LONG_PULSE, l);
            // index past the last register must be ignored
            write_reg(8'(REG_LONG_PULSE) + 8'($urandom_range(1, 252)), 16'($urandom));
            mark_set  = m;
            space_set = s;
            short_set = sh;
            long_set  = l;
        end
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0)
                run_noise();
            else
                run_burst(stop_at);
        end
    endtask

    initial begin
        int unsigned g;
        wait (aresetn);
        forever begin
            g = pick_gap(recv_calm);
            if (g > 0) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (g - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int unsigned r;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: field extremes, wrap, leader, one and zero bits, bad pulses
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h0000_0005, 32'h0000_0000);
        send_sample(32'd200,       32'hFFFF_FFFF);
        send_sample(32'd300,       32'h0000_0000);
        send_sample(32'd9300,      32'hFFFF_FFFF);
        send_sample(32'd13800,     32'h0000_0000);
        send_sample(32'd14362,     32'hFFFF_FFFF);
        send_sample(32'd14924,     32'h0000_0000);
        send_sample(32'd15486,     32'hFFFF_FFFF);
        send_sample(32'd17173,     32'h0000_0000);
        send_sample(32'd17735,     32'hAAAA_AAAA);
        send_sample(32'd20735,     32'h0000_0000);
        send_sample(32'd26735,     32'h5555_5555);
        send_sample(32'd31235,     32'h0000_0000);
        send_sample(32'd31235,     32'hFFFF_FFFF);
        send_sample(32'hFFFF_FF00, 32'h0000_0000);
        send_sample(32'h0000_0100, 32'hFFFF_0000);

        run_phase(LEADER_MARK_RST, LEADER_SPACE_RST, SHORT_PULSE_RST, LONG_PULSE_RST, 1'b0);
        run_phase(16'd900, 16'd450, 16'd56, 16'd168, 1'b1);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_phase(16'hFFFF, 16'd30000, 16'd6000, 16'd18000, 1'b1);
        repeat (2) begin
            r = $urandom_range(160, 65535);
            run_phase(16'(r), 16'(r / 2), 16'(r / 16), 16'(r * 3 / 16), 1'b1);
        end
        run_phase(LEADER_MARK_RST, LEADER_SPACE_RST, SHORT_PULSE_RST, LONG_PULSE_RST, 1'b1);

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && codes_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
design/mipd_pkg.sv
design/mipd_ram.sv
design/mipd_ctrl.sv
design/mipd_datapath.sv
design/multichannel_ir_pulse_decoder.sv
design/mipd_checker.sv
bench/ir_code_checker.sv
bench/multichannel_ir_pulse_decoder_tb.sv
